// ===== hw/rtl/necir_pkg.sv =====
// Shared types and constants for the NEC infrared frame decoder.
// No dependencies; used by every module of the decoder.
package necir_pkg;

   localparam int FRAME_BITS  = 32;
   localparam int COUNT_W     = $clog2(FRAME_BITS);
   localparam int TICK_W      = 16;
   localparam int ADDR_W      = 16;
   localparam int KEY_W       = 8;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int RSP_DATA_W  = ADDR_W + KEY_W + FRAME_BITS;

   localparam logic [ADDR_W-1:0] RESET_DEVICE_ADDRESS = 16'hA07F;
   localparam logic [TICK_W-1:0] RESET_START_MIN      = 16'd2200;
   localparam logic [TICK_W-1:0] RESET_START_MAX      = 16'd2600;
   localparam logic [TICK_W-1:0] RESET_REPEAT_MIN     = 16'd1800;
   localparam logic [TICK_W-1:0] RESET_ZERO_MIN       = 16'd150;
   localparam logic [TICK_W-1:0] RESET_BIT_SPLIT      = 16'd300;
   localparam logic [TICK_W-1:0] RESET_ONE_MAX        = 16'd500;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEVICE_ADDRESS = 3'd0,
      CSR_START_MIN      = 3'd1,
      CSR_START_MAX      = 3'd2,
      CSR_REPEAT_MIN     = 3'd3,
      CSR_ZERO_MIN       = 3'd4,
      CSR_BIT_SPLIT      = 3'd5,
      CSR_ONE_MAX        = 3'd6
   } csr_index_type;

   typedef enum logic {
      CMD_EDGE    = 1'b0,
      CMD_TIMEOUT = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      KIND_IDLE  = 2'd0,
      KIND_START = 2'd1,
      KIND_BIT0  = 2'd2,
      KIND_BIT1  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CMD_FAIL = 2'd1,
      STATUS_ADDR_BAD = 2'd2
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] device_address;
      logic [TICK_W-1:0] start_min;
      logic [TICK_W-1:0] start_max;
      logic [TICK_W-1:0] repeat_min;
      logic [TICK_W-1:0] zero_min;
      logic [TICK_W-1:0] bit_split;
      logic [TICK_W-1:0] one_max;
   } cfg_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
   } event_type;

endpackage

// ===== hw/rtl/necir_csr.sv =====
// Configuration registers of the NEC decoder: window bounds and device address.
// Depends on necir_pkg.
module necir_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [necir_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [necir_pkg::TICK_W-1:0]      csr_wdata,
   output necir_pkg::cfg_type               cfg
);

   necir_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            necir_pkg::CSR_DEVICE_ADDRESS: cfg_in.device_address = csr_wdata;
            necir_pkg::CSR_START_MIN:      cfg_in.start_min      = csr_wdata;
            necir_pkg::CSR_START_MAX:      cfg_in.start_max      = csr_wdata;
            necir_pkg::CSR_REPEAT_MIN:     cfg_in.repeat_min     = csr_wdata;
            necir_pkg::CSR_ZERO_MIN:       cfg_in.zero_min       = csr_wdata;
            necir_pkg::CSR_BIT_SPLIT:      cfg_in.bit_split      = csr_wdata;
            necir_pkg::CSR_ONE_MAX:        cfg_in.one_max        = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= necir_pkg::RESET_DEVICE_ADDRESS;
         cfg_ff.start_min      <= necir_pkg::RESET_START_MIN;
         cfg_ff.start_max      <= necir_pkg::RESET_START_MAX;
         cfg_ff.repeat_min     <= necir_pkg::RESET_REPEAT_MIN;
         cfg_ff.zero_min       <= necir_pkg::RESET_ZERO_MIN;
         cfg_ff.bit_split      <= necir_pkg::RESET_BIT_SPLIT;
         cfg_ff.one_max        <= necir_pkg::RESET_ONE_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/necir_classify.sv =====
// Front end: sorts an edge interval or timeout into an event kind.
// Depends on necir_pkg; intervals in no window yield no event.
module necir_classify (
   input  necir_pkg::cfg_type          cfg,
   input  logic                        command,
   input  logic [necir_pkg::TICK_W-1:0] interval,
   output necir_pkg::event_type        evt
);

   logic in_repeat, in_start, in_zero, in_one;

   assign in_repeat = (interval > cfg.repeat_min) && (interval < cfg.start_min);
   assign in_start  = (interval > cfg.start_min)  && (interval < cfg.start_max);
   assign in_zero   = (interval > cfg.zero_min)   && (interval < cfg.bit_split);
   assign in_one    = (interval > cfg.bit_split)  && (interval < cfg.one_max);

   always_comb begin
      evt.valid = 1'b1;
      evt.kind  = necir_pkg::KIND_IDLE;
      if (command == necir_pkg::CMD_TIMEOUT || in_repeat) begin
         evt.kind = necir_pkg::KIND_IDLE;
      end else if (in_start) begin
         evt.kind = necir_pkg::KIND_START;
      end else if (in_zero) begin
         evt.kind = necir_pkg::KIND_BIT0;
      end else if (in_one) begin
         evt.kind = necir_pkg::KIND_BIT1;
      end else begin
         evt.valid = 1'b0;
      end
   end

endmodule

// ===== hw/rtl/necir_queue.sv =====
// Short event queue between the classifier and the frame assembler.
// Depends on necir_pkg.
module necir_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  necir_pkg::kind_type push_kind,
   output logic                full,
   output logic                not_empty,
   input  logic                pop,
   output necir_pkg::kind_type pop_kind
);

   necir_pkg::kind_type             mem_ff [necir_pkg::QUEUE_DEPTH];
   logic [necir_pkg::QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [necir_pkg::QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [necir_pkg::QUEUE_AW:0]    count_ff, count_in;
   logic                            do_push, do_pop;

   assign full      = (count_ff == (necir_pkg::QUEUE_AW+1)'(necir_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_kind  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/necir_frame.sv =====
// Back end: shifts bits into the frame word and registers the finished result.
// Depends on necir_pkg.
module necir_frame (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [necir_pkg::ADDR_W-1:0]        device_address,
   input  logic                                evt_valid,
   input  necir_pkg::kind_type                 evt_kind,
   output logic                                evt_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [necir_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [necir_pkg::STATUS_W-1:0]      rsp_tuser
);

   logic                                  receiving_ff, receiving_in;
   logic [necir_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic [necir_pkg::FRAME_BITS-1:0]      word_ff, word_in;
   logic                                  valid_ff, valid_in;
   logic [necir_pkg::RSP_DATA_W-1:0]      data_ff, data_in;
   logic [necir_pkg::STATUS_W-1:0]        status_ff, status_in;
   logic [necir_pkg::FRAME_BITS-1:0]      next_word;
   logic [necir_pkg::ADDR_W-1:0]          addr;
   logic [necir_pkg::KEY_W-1:0]           key, inv;
   logic                                  take;

   assign evt_pop   = !valid_ff || rsp_tready;
   assign take      = evt_pop && evt_valid;
   assign next_word = {word_ff[necir_pkg::FRAME_BITS-2:0], evt_kind == necir_pkg::KIND_BIT1};
   assign addr      = next_word[31:16];
   assign key       = next_word[15:8];
   assign inv       = next_word[7:0];

   always_comb begin
      receiving_in = receiving_ff;
      count_in     = count_ff;
      word_in      = word_ff;
      valid_in     = valid_ff && !rsp_tready;
      data_in      = data_ff;
      status_in    = status_ff;
      if (take) begin
         case (evt_kind)
            necir_pkg::KIND_IDLE: begin
               receiving_in = 1'b0;
               count_in     = '0;
               word_in      = '0;
            end
            necir_pkg::KIND_START: begin
               receiving_in = 1'b1;
               count_in     = '0;
               word_in      = '0;
            end
            necir_pkg::KIND_BIT0, necir_pkg::KIND_BIT1: begin
               if (receiving_ff) begin
                  word_in  = next_word;
                  count_in = count_ff + 1'b1;
                  if (count_ff == necir_pkg::COUNT_W'(necir_pkg::FRAME_BITS - 1)) begin
                     receiving_in = 1'b0;
                     count_in     = '0;
                     word_in      = '0;
                     valid_in     = 1'b1;
                     data_in      = {next_word, key, addr};
                     if (key != ~inv) begin
                        status_in = necir_pkg::STATUS_CMD_FAIL;
                     end else if (addr != device_address) begin
                        status_in = necir_pkg::STATUS_ADDR_BAD;
                     end else begin
                        status_in = necir_pkg::STATUS_OK;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff <= 1'b0;
         count_ff     <= '0;
         word_ff      <= '0;
         valid_ff     <= 1'b0;
      end else begin
         receiving_ff <= receiving_in;
         count_ff     <= count_in;
         word_ff      <= word_in;
         valid_ff     <= valid_in;
      end
      data_ff   <= data_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = status_ff;

endmodule

// ===== hw/rtl/nec_ir_frame_decoder_core.sv =====
// NEC infrared frame decoder, top level: classifier, event queue, frame assembler.
// Depends on necir_pkg, necir_csr, necir_classify, necir_queue and necir_frame.
//
// Each request is one falling-edge interval in timer ticks, or a timeout
// (req_tuser high). Requests are sorted into start, repeat, zero and one by
// the csr_ windows and queued (four entries); intervals in no window are
// dropped at once. The assembler takes one queued event per cycle, so the
// block sustains one request per clock while rsp_tready is high; a frame of
// 32 bits yields one registered response, whose rsp_tvalid rises once its last
// request has passed the queue and the assembler. The user must write thresholds
// through csr_we/csr_index/csr_wdata only while idle; the block does not check it.
module nec_ir_frame_decoder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [necir_pkg::TICK_W-1:0]        req_tdata,  // interval
   input  logic                                req_tuser,  // command
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [necir_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // address, key_code, raw_frame
   output logic [necir_pkg::STATUS_W-1:0]      rsp_tuser,  // frame_status
   input  logic                                csr_we,
   input  logic [necir_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [necir_pkg::TICK_W-1:0]        csr_wdata
);

   necir_pkg::cfg_type   cfg;
   necir_pkg::event_type evt;
   necir_pkg::kind_type  pop_kind;
   logic                 q_full, q_not_empty, q_pop;

   necir_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   necir_classify u_classify (
      .cfg      (cfg),
      .command  (req_tuser),
      .interval (req_tdata),
      .evt      (evt)
   );

   assign req_tready = !q_full;

   necir_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && evt.valid),
      .push_kind (evt.kind),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .pop_kind  (pop_kind)
   );

   necir_frame u_frame (
      .clock          (clock),
      .reset          (reset),
      .device_address (cfg.device_address),
      .evt_valid      (q_not_empty),
      .evt_kind       (pop_kind),
      .evt_pop        (q_pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser)
   );

endmodule

// ===== hw/rtl/necir_checker.sv =====
// Port-level checks of the NEC decoder, bound to the top level.
// Depends on necir_pkg and nec_ir_frame_decoder_core.
module necir_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [necir_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic [necir_pkg::STATUS_W-1:0]      rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == necir_pkg::STATUS_OK
                  || rsp_tuser == necir_pkg::STATUS_CMD_FAIL
                  || rsp_tuser == necir_pkg::STATUS_ADDR_BAD)
      else $error("undefined frame status");

   a_fields_match_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] == rsp_tdata[55:40]
                  && rsp_tdata[23:16] == rsp_tdata[39:32])
      else $error("address or key code disagrees with raw frame");

   a_ok_means_cmd_check: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == necir_pkg::STATUS_OK
         |-> rsp_tdata[39:32] == ~rsp_tdata[31:24])
      else $error("accepted frame fails command check");

endmodule

bind nec_ir_frame_decoder_core necir_checker u_necir_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== verif/nec_ir_frame_decoder_core_tb.sv =====
// Self-checking testbench for nec_ir_frame_decoder_core: directed rows, then random
// NEC frames and noise under several threshold settings, checked by a frame predictor.
// Depends on necir_pkg and the decoder RTL only.
module nec_ir_frame_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import necir_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 12;
   localparam int DIRECTED_ROWS  = 25;
   localparam logic [TICK_W-1:0] DIR_START = 16'd2400;
   localparam logic [TICK_W-1:0] DIR_ZERO  = 16'd200;
   localparam logic [TICK_W-1:0] DIR_ONE   = 16'd400;

   typedef enum int {IV_NONE, IV_REPEAT, IV_START, IV_ZERO, IV_ONE} interval_class_type;

   typedef struct packed {
      status_type            status;
      logic [ADDR_W-1:0]     address;
      logic [KEY_W-1:0]      key_code;
      logic [FRAME_BITS-1:0] raw_frame;
   } frame_result_type;

   typedef struct {
      command_type           cmd;
      logic [TICK_W-1:0]     ticks;
      logic [FRAME_BITS-1:0] word;
      int                    top_bit;
      int                    nbits;
      bit                    typed;
      status_type            status;
   } plan_row_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [TICK_W-1:0]      req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [TICK_W-1:0]      csr_wdata  = '0;

   // decoder model state
   cfg_type               thresholds;
   logic                  receiving;
   logic [5:0]            bit_count;
   logic [FRAME_BITS-1:0] shift_word;

   frame_result_type expected_frames[$];
   plan_row_type     plan [DIRECTED_ROWS];
   bit  req_idle_on = 1'b1;
   bit  rsp_idle_on = 1'b1;
   bit  long_hold_pending = 1'b0;
   int  requests_sent = 0;
   int  acting_requests = 0;
   int  frames_predicted = 0;
   int  frames_seen = 0;
   int  mismatches = 0;

   nec_ir_frame_decoder_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic interval_class_type classify(input logic [TICK_W-1:0] ticks);
      if (ticks > thresholds.repeat_min && ticks < thresholds.start_min) return IV_REPEAT;
      if (ticks > thresholds.start_min && ticks < thresholds.start_max) return IV_START;
      if (ticks > thresholds.zero_min && ticks < thresholds.bit_split) return IV_ZERO;
      if (ticks > thresholds.bit_split && ticks < thresholds.one_max) return IV_ONE;
      return IV_NONE;
   endfunction

   function automatic void clear_frame();
      receiving = 1'b0;
      bit_count = '0;
      shift_word = '0;
   endfunction

   // advances the model by one request; returns 1 when a frame completes
   function automatic bit predict_decode(input command_type cmd, input logic [TICK_W-1:0] ticks,
                                         output frame_result_type res, output bit acted);
      interval_class_type cls;
      logic [FRAME_BITS-1:0] w;
      res = '0;
      acted = 1'b1;
      cls = classify(ticks);
      if (cmd == CMD_TIMEOUT || cls == IV_REPEAT) begin
         clear_frame();
      end else if (cls == IV_START) begin
         clear_frame();
         receiving = 1'b1;
      end else if (receiving && (cls == IV_ZERO || cls == IV_ONE)) begin
         shift_word = {shift_word[FRAME_BITS-2:0], cls == IV_ONE};
         bit_count = bit_count + 6'd1;
         if (bit_count == FRAME_BITS) begin
            w = shift_word;
            res.address = w[31:16];
            res.key_code = w[15:8];
            res.raw_frame = w;
            if (w[15:8] != ~w[7:0]) res.status = STATUS_CMD_FAIL;
            else if (w[31:16] != thresholds.device_address) res.status = STATUS_ADDR_BAD;
            else res.status = STATUS_OK;
            clear_frame();
            return 1'b1;
         end
      end else begin
         acted = 1'b0;
      end
      return 1'b0;
   endfunction

   // random interval aimed at one class, often right on a threshold
   function automatic logic [TICK_W-1:0] pick_interval(input interval_class_type want);
      int lo;
      int hi;
      logic [TICK_W-1:0] cand;
      case (want)
         IV_REPEAT: begin lo = thresholds.repeat_min; hi = thresholds.start_min; end
         IV_START:  begin lo = thresholds.start_min;  hi = thresholds.start_max; end
         IV_ZERO:   begin lo = thresholds.zero_min;   hi = thresholds.bit_split; end
         IV_ONE:    begin lo = thresholds.bit_split;  hi = thresholds.one_max; end
         default:   begin lo = 0; hi = 0; end
      endcase
      cand = '0;
      for (int k = 0; k < 64; k++) begin
         if (hi > lo + 1 && $urandom_range(0, 3) != 0) begin
            cand = TICK_W'($urandom_range(lo + 1, hi - 1));
         end else if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 5))
               0: cand = thresholds.repeat_min;
               1: cand = thresholds.start_min;
               2: cand = thresholds.start_max;
               3: cand = thresholds.zero_min;
               4: cand = thresholds.bit_split;
               default: cand = thresholds.one_max;
            endcase
            cand = cand + TICK_W'($urandom_range(0, 2)) - 16'd1;
         end else begin
            cand = TICK_W'($urandom);
         end
         if (classify(cand) == want) return cand;
      end
      return cand;
   endfunction

   task automatic offer(input command_type cmd, input logic [TICK_W-1:0] ticks,
                        input bit has_typed = 1'b0, input frame_result_type typed = '0);
      frame_result_type res;
      bit done;
      bit acted;
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= ticks;
      do @(posedge clock); while (req_tready !== 1'b1);
      done = predict_decode(cmd, ticks, res, acted);
      requests_sent++;
      if (acted) acting_requests++;
      if (done) frames_predicted++;
      if (has_typed) expected_frames.push_back(typed);
      else if (done) expected_frames.push_back(res);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [TICK_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_DEVICE_ADDRESS: thresholds.device_address = value;
         CSR_START_MIN:      thresholds.start_min = value;
         CSR_START_MAX:      thresholds.start_max = value;
         CSR_REPEAT_MIN:     thresholds.repeat_min = value;
         CSR_ZERO_MIN:       thresholds.zero_min = value;
         CSR_BIT_SPLIT:      thresholds.bit_split = value;
         CSR_ONE_MAX:        thresholds.one_max = value;
         default: ;
      endcase
   endtask

   // drain all responses, let queued events retire, then rewrite every register
   task automatic load_thresholds(input cfg_type c);
      req_tvalid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(CSR_DEVICE_ADDRESS, c.device_address);
      csr_write(CSR_START_MIN, c.start_min);
      csr_write(CSR_START_MAX, c.start_max);
      csr_write(CSR_REPEAT_MIN, c.repeat_min);
      csr_write(CSR_ZERO_MIN, c.zero_min);
      csr_write(CSR_BIT_SPLIT, c.bit_split);
      csr_write(CSR_ONE_MAX, c.one_max);
      csr_we <= 1'b0;
   endtask

   task automatic send_frame(input logic [FRAME_BITS-1:0] word, input bit broken);
      int cut;
      cut = broken ? $urandom_range(0, FRAME_BITS - 1) : -1;
      offer(CMD_EDGE, pick_interval(IV_START));
      for (int j = FRAME_BITS - 1; j >= 0; j--) begin
         if (j == cut) begin
            if ($urandom_range(0, 2) == 0) offer(CMD_TIMEOUT, TICK_W'($urandom));
            else if ($urandom_range(0, 1) == 0) offer(CMD_EDGE, pick_interval(IV_REPEAT));
            else offer(CMD_EDGE, pick_interval(IV_START));
            return;
         end
         if ($urandom_range(0, 19) == 0) offer(CMD_EDGE, pick_interval(IV_NONE));
         offer(CMD_EDGE, pick_interval(word[j] ? IV_ONE : IV_ZERO));
      end
   endtask

   task automatic run_traffic(input int target, input int raw_cap);
      int eff0;
      int raw0;
      int r;
      logic [ADDR_W-1:0] addr;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] inv;
      eff0 = acting_requests;
      raw0 = requests_sent;
      while (acting_requests - eff0 < target && requests_sent - raw0 < raw_cap) begin
         r = $urandom_range(0, 99);
         if (r < 80) begin
            addr = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom) : thresholds.device_address;
            key  = KEY_W'($urandom);
            inv  = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom) : ~key;
            send_frame({addr, key, inv}, $urandom_range(0, 9) == 0);
         end else if (r < 92) begin
            offer(($urandom_range(0, 3) == 0) ? CMD_TIMEOUT : CMD_EDGE, TICK_W'($urandom));
         end else if (r < 96) begin
            offer(CMD_TIMEOUT, TICK_W'($urandom));
         end else begin
            offer(CMD_EDGE, pick_interval(IV_REPEAT));
         end
      end
   endtask

   task automatic report(input string what, input frame_result_type want,
                         input frame_result_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t %s: exp st=%0d a=%h k=%h w=%h got st=%0d a=%h k=%h w=%h", $realtime, what,
                  want.status, want.address, want.key_code, want.raw_frame,
                  got.status, got.address, got.key_code, got.raw_frame);
   endtask

   // response checker
   always @(posedge clock) begin
      frame_result_type want;
      frame_result_type got;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got.status    = status_type'(rsp_tuser);
         got.address   = rsp_tdata[ADDR_W-1:0];
         got.key_code  = rsp_tdata[ADDR_W +: KEY_W];
         got.raw_frame = rsp_tdata[ADDR_W+KEY_W +: FRAME_BITS];
         frames_seen++;
         if (expected_frames.size() == 0) begin
            report("unexpected frame", '0, got);
         end else begin
            want = expected_frames.pop_front();
            if (got.status !== want.status || got.address !== want.address ||
                got.key_code !== want.key_code || got.raw_frame !== want.raw_frame)
               report("frame mismatch", want, got);
         end
      end
   end

   // response backpressure
   initial begin
      int ready_gap;
      ready_gap = 0;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            ready_gap = LONG_HOLD;
         end else if (ready_gap == 0 && rsp_idle_on && $urandom_range(0, 5) == 0) begin
            ready_gap = $urandom_range(1, 3);
         end
         if (ready_gap > 0) begin
            ready_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("timeout: no handshake for %0d cycles, %0d frames pending",
               WATCHDOG_LIMIT, expected_frames.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      frame_result_type typed_res;
      logic [FRAME_BITS-1:0] w;
      bit b;
      bit last;
      cfg_type c;

      thresholds = '{RESET_DEVICE_ADDRESS, RESET_START_MIN, RESET_START_MAX, RESET_REPEAT_MIN,
                     RESET_ZERO_MIN, RESET_BIT_SPLIT, RESET_ONE_MAX};
      clear_frame();
      plan = '{
         '{CMD_TIMEOUT, 16'hFFFF, 32'h0,          0,  0, 1'b0, STATUS_OK},
         '{CMD_EDGE,    16'h0000, 32'h0,          0,  0, 1'b0, STATUS_OK},
         '{CMD_EDGE,    16'hFFFF, 32'h0,          0,  0, 1'b0, STATUS_OK},
         '{CMD_EDGE,    16'd200,  32'h0,          0,  0, 1'b0, STATUS_OK},
         '{CMD_EDGE,    16'd0,    32'hA07F_00FF, 31, 32, 1'b1, STATUS_OK},
         '{CMD_EDGE,    16'd0,    32'h1234_5A5A, 31, 32, 1'b1, STATUS_CMD_FAIL},
         '{CMD_EDGE,    16'd0,    32'h1234_5AA5, 31, 32, 1'b1, STATUS_ADDR_BAD},
         '{CMD_EDGE,    16'd0,    32'hFFFF_00FF, 31, 32, 1'b1, STATUS_ADDR_BAD},
         '{CMD_EDGE,    16'd0,    32'h0000_FF00, 31, 32, 1'b1, STATUS_ADDR_BAD},
         '{CMD_EDGE,    16'd0,    32'hC3C3_3CC3, 31, 16, 1'b0, STATUS_OK},
         '{CMD_EDGE,    16'd150,  32'h0,          0,  0, 1'b0, STATUS_OK},
         '{CMD_EDGE,    16'd300,  32'h0,          0,  0, 1'b0, STATUS_OK},
         '{CMD_EDGE,    16'd500,  32'h0,          0,  0, 1'b0, STATUS_OK},
         '{CMD_EDGE,    16'd1800, 32'h0,          0,  0, 1'b0, STATUS_OK},
         '{CMD_EDGE,    16'd2200, 32'h0,          0,  0, 1'b0, STATUS_OK},
         '{CMD_EDGE,    16'd2600, 32'h0,          0,  0, 1'b0, STATUS_OK},
         '{CMD_EDGE,    16'd1000, 32'h0,          0,  0, 1'b0, STATUS_OK},
         '{CMD_EDGE,    16'd0,    32'hC3C3_3CC3, 15, 16, 1'b1, STATUS_ADDR_BAD},
         '{CMD_EDGE,    16'd0,    32'hA07F_00FF, 31, 10, 1'b0, STATUS_OK},
         '{CMD_TIMEOUT, 16'h0000, 32'h0,          0,  0, 1'b0, STATUS_OK},
         '{CMD_EDGE,    16'd400,  32'h0,          0,  0, 1'b0, STATUS_OK},
         '{CMD_EDGE,    16'd0,    32'hA07F_00FF, 31, 12, 1'b0, STATUS_OK},
         '{CMD_EDGE,    16'd2000, 32'h0,          0,  0, 1'b0, STATUS_OK},
         '{CMD_EDGE,    16'd0,    32'h5A5A_5A5A, 31, 20, 1'b0, STATUS_OK},
         '{CMD_EDGE,    16'd0,    32'hA07F_00FF, 31, 32, 1'b1, STATUS_OK}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed rows; a row with bits opens a frame when it starts at the MSB
      foreach (plan[n]) begin
         if (plan[n].nbits == 0) begin
            offer(plan[n].cmd, plan[n].ticks);
         end else begin
            w = plan[n].word;
            typed_res = '{plan[n].status, w[31:16], w[15:8], w};
            if (plan[n].top_bit == FRAME_BITS - 1) offer(CMD_EDGE, DIR_START);
            for (int j = 0; j < plan[n].nbits; j++) begin
               b = w[plan[n].top_bit - j];
               last = plan[n].typed && (j == plan[n].nbits - 1);
               offer(CMD_EDGE, b ? DIR_ONE : DIR_ZERO, last, typed_res);
            end
         end
      end

      run_traffic(160, 100000);

      c.zero_min   = TICK_W'($urandom_range(0, 2000));
      c.bit_split  = c.zero_min + TICK_W'($urandom_range(2, 3000));
      c.one_max    = c.bit_split + TICK_W'($urandom_range(2, 3000));
      c.repeat_min = c.one_max + TICK_W'($urandom_range(0, 5000));
      c.start_min  = c.repeat_min + TICK_W'($urandom_range(2, 5000));
      c.start_max  = c.start_min + TICK_W'($urandom_range(2, 20000));
      c.device_address = ADDR_W'($urandom);
      load_thresholds(c);
      run_traffic(80, 100000);
      long_hold_pending = 1'b1;
      run_traffic(140, 100000);

      // overlapping windows: repeat over zero and one, start over one
      load_thresholds('{16'h5AA5, 16'd380, 16'd600, 16'd250, 16'd100, 16'd300, 16'd800});
      run_traffic(140, 100000);

      load_thresholds('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      run_traffic(20, 60);

      load_thresholds('{16'h0000, 16'd40000, 16'hFFFF, 16'd30000, 16'd0, 16'd1000, 16'd20000});
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_traffic(200, 100000);

      req_tvalid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d requests (%0d acting) over reset, random, overlapping, empty and wide windows",
               requests_sent, acting_requests);
      $display("%0d frames predicted, %0d checked, %0d mismatches, one long response hold-off",
               frames_predicted, frames_seen, mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
